// ===== rtl/core/endstop_qualifier_assert.svh =====
// Assertion macros for the endstop qualifier.
// Used by the top level only; needs i_clk and i_rst_n in scope.
`ifndef ENDSTOP_QUALIFIER_ASSERT_SVH
`define ENDSTOP_QUALIFIER_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define ESQ_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("endstop qualifier check failed");

// Condition holds in the cycle after the trigger.
`define ESQ_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("endstop qualifier check failed");

`endif

// ===== rtl/core/esq_pkg.sv =====
// Shared types, pin and flag positions, and the side check function
// of the endstop qualifier. No dependencies.
package esq_pkg;

    localparam int PIN_COUNT = 15;
    localparam int HIT_COUNT = 7;
    localparam int CFG_IDX_W = 3;

    typedef logic [PIN_COUNT-1:0] t_pins;
    typedef logic [HIT_COUNT-1:0] t_hits;
    typedef logic [2:0]           t_axes;
    typedef logic [3:0]           t_count;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx CFG_ENDSTOPS_EN = 3'd0;
    localparam t_cfg_idx CFG_PROBE_EN    = 3'd1;
    localparam t_cfg_idx CFG_NOISE_THR   = 3'd2;
    localparam t_cfg_idx CFG_INVERT_MASK = 3'd3;
    localparam t_cfg_idx CFG_X_DUAL      = 3'd4;
    localparam t_cfg_idx CFG_Y_DUAL      = 3'd5;
    localparam t_cfg_idx CFG_Z_MULTI     = 3'd6;

    // z_multi codes
    localparam logic [1:0] Z_SINGLE = 2'd0;
    localparam logic [1:0] Z_DUAL   = 2'd1;

    // Switch-set masks for one side of an axis
    localparam logic [2:0] ALL_SINGLE = 3'b001;
    localparam logic [2:0] ALL_DUAL   = 3'b011;
    localparam logic [2:0] ALL_TRIPLE = 3'b111;

    // Pin positions in the pin vector
    localparam int PIN_XMIN  = 0;
    localparam int PIN_XMAX  = 1;
    localparam int PIN_YMIN  = 2;
    localparam int PIN_YMAX  = 3;
    localparam int PIN_ZMIN  = 4;
    localparam int PIN_ZMAX  = 5;
    localparam int PIN_X2MIN = 6;
    localparam int PIN_X2MAX = 7;
    localparam int PIN_Y2MIN = 8;
    localparam int PIN_Y2MAX = 9;
    localparam int PIN_Z2MIN = 10;
    localparam int PIN_Z2MAX = 11;
    localparam int PIN_Z3MIN = 12;
    localparam int PIN_Z3MAX = 13;
    localparam int PIN_PROBE = 14;

    // Trip flag positions
    localparam int HIT_XMIN  = 0;
    localparam int HIT_YMIN  = 1;
    localparam int HIT_ZMIN  = 2;
    localparam int HIT_PROBE = 3;
    localparam int HIT_XMAX  = 4;
    localparam int HIT_YMAX  = 5;
    localparam int HIT_ZMAX  = 6;

    typedef struct packed {
        logic       endstops_enabled;
        logic       probe_enabled;
        t_count     noise_threshold;
        t_pins      invert_mask;
        logic       x_dual;
        logic       y_dual;
        logic [1:0] z_multi;
    } t_cfg;

    typedef struct packed {
        t_pins state;
        logic  settling;
    } t_filt;

    typedef struct packed {
        t_hits trips;
        t_axes stop;
    } t_trip;

    typedef struct packed {
        logic trip;
        logic stop;
    } t_side;

    // hits already masked by all_mask; stop when any trips, unless homing
    // separately on a multi-switch side where all must trip
    function automatic t_side check_side(input logic [2:0] hits,
                                         input logic [2:0] all_mask,
                                         input logic       separately);
        t_side r;
        r.trip = |hits;
        r.stop = r.trip && ((all_mask == ALL_SINGLE) || !separately || (hits == all_mask));
        return r;
    endfunction

endpackage

// ===== rtl/core/esq_filter.sv =====
// Live pin state and noise countdown of the endstop qualifier.
// Depends on esq_pkg.
module esq_filter #(
    parameter int SWITCH_COUNT = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  esq_pkg::t_pins i_raw,
    input  esq_pkg::t_cfg  i_cfg,
    output esq_pkg::t_filt o_filt
);

    logic [SWITCH_COUNT-1:0] r_live, r_prev, r_valid;
    logic [SWITCH_COUNT-1:0] n_live, n_prev, n_valid;
    logic [SWITCH_COUNT-1:0] live_new;
    esq_pkg::t_count         r_cnt, n_cnt;
    logic                    active;

    assign active   = i_cfg.endstops_enabled | i_cfg.probe_enabled;
    assign live_new = i_raw[SWITCH_COUNT-1:0] ^ i_cfg.invert_mask[SWITCH_COUNT-1:0];

    always_comb begin
        n_live  = r_live;
        n_prev  = r_prev;
        n_valid = r_valid;
        n_cnt   = r_cnt;
        if (i_cfg.noise_threshold == '0) begin
            n_cnt = '0;
            if (active) begin
                n_live  = live_new;
                n_prev  = live_new;
                n_valid = live_new;
            end
            o_filt.state = esq_pkg::t_pins'(n_live);
        end else begin
            n_live = live_new;
            if (r_prev != live_new) begin
                n_cnt  = i_cfg.noise_threshold;
                n_prev = live_new;
            end else if (r_cnt != '0) begin
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    n_valid = live_new;
                end
            end
            o_filt.state = esq_pkg::t_pins'(n_valid);
        end
        o_filt.settling = (n_cnt != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live  <= '0;
            r_prev  <= '0;
            r_valid <= '0;
            r_cnt   <= '0;
        end else if (i_take) begin
            r_live  <= n_live;
            r_prev  <= n_prev;
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/esq_check.sv =====
// Per-axis switch tests: trip flags and axis stops for one tick.
// Depends on esq_pkg.
module esq_check (
    input  esq_pkg::t_pins i_state,
    input  esq_pkg::t_cfg  i_cfg,
    input  esq_pkg::t_axes i_moving,
    input  esq_pkg::t_axes i_negative,
    input  logic           i_separately,
    output esq_pkg::t_trip o_trip
);

    logic [2:0]     x_all, y_all, z_all;
    logic           active, z_multi_sw;
    esq_pkg::t_side x_side, y_side, z_side, p_side;

    assign active = i_cfg.endstops_enabled | i_cfg.probe_enabled;
    assign x_all  = i_cfg.x_dual ? esq_pkg::ALL_DUAL : esq_pkg::ALL_SINGLE;
    assign y_all  = i_cfg.y_dual ? esq_pkg::ALL_DUAL : esq_pkg::ALL_SINGLE;

    always_comb begin
        case (i_cfg.z_multi)
            esq_pkg::Z_SINGLE: z_all = esq_pkg::ALL_SINGLE;
            esq_pkg::Z_DUAL:   z_all = esq_pkg::ALL_DUAL;
            default:           z_all = esq_pkg::ALL_TRIPLE;
        endcase
    end

    assign z_multi_sw = (z_all != esq_pkg::ALL_SINGLE);

    always_comb begin
        x_side = esq_pkg::check_side(
            (i_negative[0] ? {1'b0, i_state[esq_pkg::PIN_X2MIN], i_state[esq_pkg::PIN_XMIN]}
                           : {1'b0, i_state[esq_pkg::PIN_X2MAX], i_state[esq_pkg::PIN_XMAX]})
            & x_all, x_all, i_separately);
        y_side = esq_pkg::check_side(
            (i_negative[1] ? {1'b0, i_state[esq_pkg::PIN_Y2MIN], i_state[esq_pkg::PIN_YMIN]}
                           : {1'b0, i_state[esq_pkg::PIN_Y2MAX], i_state[esq_pkg::PIN_YMAX]})
            & y_all, y_all, i_separately);
        z_side = esq_pkg::check_side(
            (i_negative[2] ? {i_state[esq_pkg::PIN_Z3MIN], i_state[esq_pkg::PIN_Z2MIN],
                              i_state[esq_pkg::PIN_ZMIN]}
                           : {i_state[esq_pkg::PIN_Z3MAX], i_state[esq_pkg::PIN_Z2MAX],
                              i_state[esq_pkg::PIN_ZMAX]})
            & z_all, z_all, i_separately);
        p_side = esq_pkg::check_side({2'b00, i_state[esq_pkg::PIN_PROBE]},
                                     esq_pkg::ALL_SINGLE, i_separately);

        // single z min switch is replaced by the probe while the probe is on
        if (i_negative[2] && !z_multi_sw && i_cfg.probe_enabled) begin
            z_side = '0;
        end
        if (!(i_negative[2] && i_cfg.probe_enabled)) begin
            p_side = '0;
        end
        if (!active || !i_moving[0]) x_side = '0;
        if (!active || !i_moving[1]) y_side = '0;
        if (!active || !i_moving[2]) begin
            z_side = '0;
            p_side = '0;
        end

        o_trip.trips = '0;
        o_trip.trips[esq_pkg::HIT_XMIN]  = x_side.trip &  i_negative[0];
        o_trip.trips[esq_pkg::HIT_XMAX]  = x_side.trip & ~i_negative[0];
        o_trip.trips[esq_pkg::HIT_YMIN]  = y_side.trip &  i_negative[1];
        o_trip.trips[esq_pkg::HIT_YMAX]  = y_side.trip & ~i_negative[1];
        o_trip.trips[esq_pkg::HIT_ZMIN]  = z_side.trip &  i_negative[2];
        o_trip.trips[esq_pkg::HIT_ZMAX]  = z_side.trip & ~i_negative[2];
        o_trip.trips[esq_pkg::HIT_PROBE] = p_side.trip;
        o_trip.stop = {z_side.stop | p_side.stop, y_side.stop, x_side.stop};
    end

endmodule

// ===== rtl/core/endstop_qualifier.sv =====
// Top level of the endstop qualifier: configuration registers, handshake,
// trip flag accumulation and result register. Depends on esq_pkg,
// esq_filter, esq_check and endstop_qualifier_assert.svh.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+------------------------------------
//  in      | to block  | i_in_valid / o_in_stall      | raw_pins, axis_moving, axis_negative,
//          |           |                              | homing_separately, clear_hits
//  out     | from block| o_out_valid / i_out_stall    | hit_flags, axis_stop,
//          |           |                              | filtered_state, settling
//  cfg     | to block  | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// One item per cycle unless the output stalls: the whole tick (invert, debounce, side tests, flag
// accumulation) is one combinational pass from the input ports and the state
// registers into the result register, so each item's result appears the cycle
// after it is accepted. The result register is the only buffer; the input
// stalls only while a result waits and the output is stalled. Reset
// (synchronous, active low) clears configuration, filter state and trip flags.
module endstop_qualifier #(
    parameter int SWITCH_COUNT = 15
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  esq_pkg::t_pins            i_raw_pins,
    input  esq_pkg::t_axes            i_axis_moving,
    input  esq_pkg::t_axes            i_axis_negative,
    input  logic                      i_homing_separately,
    input  logic                      i_clear_hits,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output esq_pkg::t_hits            o_hit_flags,
    output esq_pkg::t_axes            o_axis_stop,
    output esq_pkg::t_pins            o_filtered_state,
    output logic                      o_settling,
    // configuration write port
    input  logic                      i_cfg_we,
    input  esq_pkg::t_cfg_idx         i_cfg_idx,
    input  esq_pkg::t_pins            i_cfg_data
);

    esq_pkg::t_cfg  r_cfg;
    esq_pkg::t_filt filt;
    esq_pkg::t_trip trip;
    esq_pkg::t_hits r_trip, n_trip;
    esq_pkg::t_axes r_stop;
    esq_pkg::t_pins r_state;
    logic           r_settling;
    logic           r_out_valid;
    logic           take;

    // Accept while the result register is empty or being drained
    assign o_in_stall = r_out_valid & i_out_stall;
    assign take       = i_in_valid & ~o_in_stall;

    // Configuration decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                esq_pkg::CFG_ENDSTOPS_EN: r_cfg.endstops_enabled <= i_cfg_data[0];
                esq_pkg::CFG_PROBE_EN:    r_cfg.probe_enabled    <= i_cfg_data[0];
                esq_pkg::CFG_NOISE_THR:   r_cfg.noise_threshold  <= i_cfg_data[3:0];
                esq_pkg::CFG_INVERT_MASK: r_cfg.invert_mask      <= i_cfg_data;
                esq_pkg::CFG_X_DUAL:      r_cfg.x_dual           <= i_cfg_data[0];
                esq_pkg::CFG_Y_DUAL:      r_cfg.y_dual           <= i_cfg_data[0];
                esq_pkg::CFG_Z_MULTI:     r_cfg.z_multi          <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Live state and noise countdown; state advances only on an accepted item
    esq_filter #(
        .SWITCH_COUNT (SWITCH_COUNT)
    ) u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_raw   (i_raw_pins),
        .i_cfg   (r_cfg),
        .o_filt  (filt)
    );

    // Side tests on this tick's decision state
    esq_check u_check (
        .i_state      (filt.state),
        .i_cfg        (r_cfg),
        .i_moving     (i_axis_moving),
        .i_negative   (i_axis_negative),
        .i_separately (i_homing_separately),
        .o_trip       (trip)
    );

    // Drop old flags on request, then add this tick's trips
    assign n_trip = (i_clear_hits ? '0 : r_trip) | trip.trips;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trip      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_trip <= n_trip;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; hold while stalled
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_stop     <= trip.stop;
            r_state    <= filt.state;
            r_settling <= filt.settling;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_hit_flags      = r_trip;
    assign o_axis_stop      = r_stop;
    assign o_filtered_state = r_state;
    assign o_settling       = r_settling;

`include "endstop_qualifier_assert.svh"

    // An accepted item always leaves a result behind
    `ESQ_ASSERT_NEXT(a_take_gives_result, take, o_out_valid)
    // A stopping x or z axis has tripped on one of its sides
    `ESQ_ASSERT_NOW(a_stop_has_flag, o_out_valid && o_axis_stop[0], o_hit_flags[esq_pkg::HIT_XMIN] || o_hit_flags[esq_pkg::HIT_XMAX])
    `ESQ_ASSERT_NOW(a_zstop_has_flag, o_out_valid && o_axis_stop[2], o_hit_flags[esq_pkg::HIT_ZMIN] || o_hit_flags[esq_pkg::HIT_ZMAX] || o_hit_flags[esq_pkg::HIT_PROBE])
    // Clearing with no axis moving leaves no flags
    `ESQ_ASSERT_NEXT(a_clear_idle, take && i_clear_hits && (i_axis_moving == '0), o_hit_flags == '0)

endmodule

// ===== tb/sv/esq_checker.sv =====
// Scoreboard for the endstop qualifier: mirrors configuration writes, predicts each tick.
// Compares every result item with the oldest prediction. Depends on esq_pkg.
`timescale 1ns / 100ps

module esq_checker
    import esq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_pins    i_raw_pins,
    input  t_axes    i_axis_moving,
    input  t_axes    i_axis_negative,
    input  logic     i_homing_separately,
    input  logic     i_clear_hits,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_hits    i_hit_flags,
    input  t_axes    i_axis_stop,
    input  t_pins    i_filtered_state,
    input  logic     i_settling,
    input  logic     i_cfg_we,
    input  t_cfg_idx i_cfg_idx,
    input  t_pins    i_cfg_data,
    output int       o_errors,
    output int       o_pending
);

    typedef struct packed {
        t_hits hits;
        t_axes stop;
        t_pins state;
        logic  settling;
    } t_tick_result;

    t_tick_result due_results[$];

    t_cfg   cfg;
    t_pins  live_pins;
    t_pins  last_live;
    t_pins  stable_pins;
    t_count settle_left;
    t_hits  trip_acc;

    // One side of one axis: set its flag on any trip, return the stop decision.
    function automatic logic test_side(input t_pins st, input int pa, input int pb,
                                       input int pc, input int n, input int hit_bit,
                                       input logic sep);
        logic [2:0] sw;
        logic [2:0] all_sw;
        sw     = {(n >= 3) ? st[pc] : 1'b0, (n >= 2) ? st[pb] : 1'b0, st[pa]};
        all_sw = (n >= 3) ? ALL_TRIPLE : ((n == 2) ? ALL_DUAL : ALL_SINGLE);
        if (sw == 3'b000)
            return 1'b0;
        trip_acc[hit_bit] = 1'b1;
        return (n < 2) || !sep || (sw == all_sw);
    endfunction

    function automatic t_tick_result qualify_tick(input t_pins raw, input t_axes mov,
                                                  input t_axes neg, input logic sep,
                                                  input logic clr);
        t_tick_result r;
        t_pins        st;
        t_axes        stop;
        logic         active;
        int           xn;
        int           yn;
        int           zn;
        active = cfg.endstops_enabled | cfg.probe_enabled;
        stop   = '0;
        if (clr)
            trip_acc = '0;

        if (cfg.noise_threshold == '0) begin
            settle_left = '0;
            if (active) begin
                live_pins   = raw ^ cfg.invert_mask;
                last_live   = live_pins;
                stable_pins = live_pins;
            end
            st = live_pins;
        end else begin
            live_pins = raw ^ cfg.invert_mask;
            if (last_live != live_pins) begin
                settle_left = cfg.noise_threshold;
                last_live   = live_pins;
            end else if (settle_left != '0) begin
                settle_left = settle_left - 1'b1;
                if (settle_left == '0)
                    stable_pins = live_pins;
            end
            st = stable_pins;
        end

        if (active) begin
            xn = cfg.x_dual ? 2 : 1;
            yn = cfg.y_dual ? 2 : 1;
            zn = (cfg.z_multi == Z_SINGLE) ? 1 : ((cfg.z_multi == Z_DUAL) ? 2 : 3);
            if (mov[0]) begin
                if (neg[0])
                    stop[0] = test_side(st, PIN_XMIN, PIN_X2MIN, PIN_X2MIN, xn, HIT_XMIN, sep);
                else
                    stop[0] = test_side(st, PIN_XMAX, PIN_X2MAX, PIN_X2MAX, xn, HIT_XMAX, sep);
            end
            if (mov[1]) begin
                if (neg[1])
                    stop[1] = test_side(st, PIN_YMIN, PIN_Y2MIN, PIN_Y2MIN, yn, HIT_YMIN, sep);
                else
                    stop[1] = test_side(st, PIN_YMAX, PIN_Y2MAX, PIN_Y2MAX, yn, HIT_YMAX, sep);
            end
            if (mov[2]) begin
                if (neg[2]) begin
                    // a single z switch gives way to the probe
                    if (zn >= 2 || !cfg.probe_enabled)
                        stop[2] = test_side(st, PIN_ZMIN, PIN_Z2MIN, PIN_Z3MIN, zn,
                                            HIT_ZMIN, sep);
                    if (cfg.probe_enabled)
                        stop[2] = test_side(st, PIN_PROBE, PIN_PROBE, PIN_PROBE, 1,
                                            HIT_PROBE, sep) | stop[2];
                end else begin
                    stop[2] = test_side(st, PIN_ZMAX, PIN_Z2MAX, PIN_Z3MAX, zn, HIT_ZMAX, sep);
                end
            end
        end

        r.hits     = trip_acc;
        r.stop     = stop;
        r.state    = st;
        r.settling = (settle_left != '0);
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_tick_result got;
        t_tick_result want;
        if (!i_rst_n) begin
            cfg         = '0;
            live_pins   = '0;
            last_live   = '0;
            stable_pins = '0;
            settle_left = '0;
            trip_acc    = '0;
            due_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENDSTOPS_EN: cfg.endstops_enabled = i_cfg_data[0];
                    CFG_PROBE_EN:    cfg.probe_enabled    = i_cfg_data[0];
                    CFG_NOISE_THR:   cfg.noise_threshold  = i_cfg_data[3:0];
                    CFG_INVERT_MASK: cfg.invert_mask      = i_cfg_data;
                    CFG_X_DUAL:      cfg.x_dual           = i_cfg_data[0];
                    CFG_Y_DUAL:      cfg.y_dual           = i_cfg_data[0];
                    CFG_Z_MULTI:     cfg.z_multi          = i_cfg_data[1:0];
                    default: ;
                endcase
            end

            // retire a result before queuing this edge's item
            if (i_out_valid && !i_out_stall) begin
                got = '{i_hit_flags, i_axis_stop, i_filtered_state, i_settling};
                if (due_results.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: result item with no prediction pending: %p",
                                 $realtime, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) begin
                        if (o_errors < 10)
                            $display(
                                "%0t: exp/act hits %b/%b stop %b/%b state %h/%h settling %b/%b",
                                $realtime, want.hits, got.hits, want.stop, got.stop,
                                want.state, got.state, want.settling, got.settling);
                        o_errors <= o_errors + 1;
                    end
                end
            end

            if (i_in_valid && !i_in_stall)
                due_results.push_back(qualify_tick(i_raw_pins, i_axis_moving, i_axis_negative,
                                                   i_homing_separately, i_clear_hits));
        end
        o_pending <= due_results.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the endstop qualifier testbench: clock, reset, stimulus and verdict.
// Depends on esq_pkg, endstop_qualifier and esq_checker.
`timescale 1ns / 100ps

module testbench;
    import esq_pkg::*;

    // z_multi codes beyond the package's; code 3 must act as triple
    localparam logic [1:0] Z_TRIPLE     = 2'd2;
    localparam logic [1:0] Z_TRIPLE_ALT = 2'd3;
    // index with no register behind it: a write must change nothing
    localparam t_cfg_idx   CFG_UNUSED   = 3'd7;

    logic     i_clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_pins    raw_pins;
    t_axes    axis_moving;
    t_axes    axis_negative;
    logic     homing_sep;
    logic     clear_hits;
    logic     out_valid;
    logic     out_stall;
    t_hits    hit_flags;
    t_axes    axis_stop;
    t_pins    filtered_state;
    logic     settling;
    logic     cfg_we;
    t_cfg_idx cfg_idx;
    t_pins    cfg_data;
    int       errors;
    int       pending;

    // no idling on either side while set
    bit       calm = 1'b0;
    // stimulus-side copy of the settings that shape the pin runs
    int       cur_thr = 0;
    t_pins    cur_inv = '0;

    endstop_qualifier u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_raw_pins          (raw_pins),
        .i_axis_moving       (axis_moving),
        .i_axis_negative     (axis_negative),
        .i_homing_separately (homing_sep),
        .i_clear_hits        (clear_hits),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_hit_flags         (hit_flags),
        .o_axis_stop         (axis_stop),
        .o_filtered_state    (filtered_state),
        .o_settling          (settling),
        .i_cfg_we            (cfg_we),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_data          (cfg_data)
    );

    esq_checker u_check (
        .i_clk               (i_clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .i_in_stall          (in_stall),
        .i_raw_pins          (raw_pins),
        .i_axis_moving       (axis_moving),
        .i_axis_negative     (axis_negative),
        .i_homing_separately (homing_sep),
        .i_clear_hits        (clear_hits),
        .i_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .i_hit_flags         (hit_flags),
        .i_axis_stop         (axis_stop),
        .i_filtered_state    (filtered_state),
        .i_settling          (settling),
        .i_cfg_we            (cfg_we),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_data          (cfg_data),
        .o_errors            (errors),
        .o_pending           (pending)
    );

    // 20 ns period
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Gap length for both sides: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Put random junk above a register's width; the block must drop it.
    function automatic t_pins with_junk(input t_pins val, input int w);
        t_pins keep;
        keep = t_pins'((1 << w) - 1);
        return (t_pins'($urandom) & ~keep) | (val & keep);
    endfunction

    // Receiver side: stall the result channel in random bursts.
    initial begin : stall_gen
        int n;
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            n = pick_gap();
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one item after a random gap; hold it until accepted.
    task automatic send_item(input t_pins raw, input t_axes mov, input t_axes neg,
                             input logic sep, input logic clr);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid      <= 1'b1;
        raw_pins      <= raw;
        axis_moving   <= mov;
        axis_negative <= neg;
        homing_sep    <= sep;
        clear_hits    <= clr;
        do @(posedge i_clk); while (in_stall);
    endtask

    // Hold the sender until every predicted result has arrived, then let the
    // result register settle before anything else happens.
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_pins data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Quiesce, then rewrite every register.
    task automatic set_cfg(input logic en, input logic pr, input t_count thr,
                           input t_pins inv, input logic xd, input logic yd,
                           input logic [1:0] zm);
        drain();
        write_reg(CFG_ENDSTOPS_EN, with_junk(t_pins'(en), 1));
        write_reg(CFG_PROBE_EN,    with_junk(t_pins'(pr), 1));
        write_reg(CFG_NOISE_THR,   with_junk(t_pins'(thr), 4));
        write_reg(CFG_INVERT_MASK, inv);
        write_reg(CFG_X_DUAL,      with_junk(t_pins'(xd), 1));
        write_reg(CFG_Y_DUAL,      with_junk(t_pins'(yd), 1));
        write_reg(CFG_Z_MULTI,     with_junk(t_pins'(zm), 2));
        cur_thr = int'(thr);
        cur_inv = inv;
    endtask

    // Pins come in runs held long enough for the debounce to validate most of
    // them; short runs act as glitches. Motion, homing mode and clears vary
    // freely from item to item.
    task automatic random_phase(input int count);
        t_pins raw;
        int    run_left;
        int    k;
        raw      = '0;
        run_left = 0;
        for (k = 0; k < count; k++) begin
            if (run_left == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: raw = raw ^ t_pins'(1 << $urandom_range(0, PIN_COUNT - 1));
                    5, 6, 7:       raw = t_pins'($urandom);
                    8:             raw = cur_inv;     // nothing triggered
                    default:       raw = ~cur_inv;    // everything triggered
                endcase
                run_left = $urandom_range(1, 2 * cur_thr + 3);
            end
            run_left--;
            send_item(raw, t_axes'($urandom), t_axes'($urandom), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 15) == 0);
        end
    endtask

    // Run out the clock if the block hangs.
    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int p;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        raw_pins      = '0;
        axis_moving   = '0;
        axis_negative = '0;
        homing_sep    = 1'b0;
        clear_hits    = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_ENDSTOPS_EN;
        cfg_data      = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // Reset settings: unfiltered and inactive, so nothing may change.
        send_item('1, 3'b111, 3'b111, 1'b1, 1'b0);
        send_item('0, 3'b111, 3'b000, 1'b0, 1'b0);

        // Single switches, plain polarity: min sides, max sides, clear, no motion.
        set_cfg(1'b1, 1'b0, 4'd0, '0, 1'b0, 1'b0, Z_SINGLE);
        write_reg(CFG_UNUSED, '1);
        send_item('0, 3'b111, 3'b111, 1'b0, 1'b0);
        send_item('1, 3'b111, 3'b111, 1'b0, 1'b0);
        send_item('1, 3'b111, 3'b000, 1'b0, 1'b0);
        send_item('1, 3'b000, 3'b000, 1'b0, 1'b1);
        send_item(t_pins'(1 << PIN_XMIN), 3'b001, 3'b001, 1'b0, 1'b0);

        // Dual switches, all pins inverted (low = triggered): homing separately
        // stops only when both switches of a side have tripped.
        set_cfg(1'b1, 1'b1, 4'd0, '1, 1'b1, 1'b1, Z_DUAL);
        send_item('0, 3'b111, 3'b111, 1'b1, 1'b1);
        send_item(t_pins'((1 << PIN_X2MIN) | (1 << PIN_Y2MIN) | (1 << PIN_Z2MIN) |
                          (1 << PIN_PROBE)), 3'b111, 3'b111, 1'b1, 1'b1);
        send_item(t_pins'((1 << PIN_X2MIN) | (1 << PIN_Y2MIN) | (1 << PIN_Z2MIN) |
                          (1 << PIN_PROBE)), 3'b111, 3'b111, 1'b0, 1'b0);

        // Probe only: it replaces the single z-min switch; z-max still tested.
        set_cfg(1'b0, 1'b1, 4'd0, '0, 1'b0, 1'b0, Z_SINGLE);
        send_item(t_pins'(1 << PIN_ZMIN), 3'b100, 3'b100, 1'b0, 1'b0);
        send_item(t_pins'((1 << PIN_ZMIN) | (1 << PIN_PROBE)), 3'b100, 3'b100, 1'b0, 1'b0);
        send_item(t_pins'(1 << PIN_ZMAX), 3'b100, 3'b000, 1'b0, 1'b0);

        // Code 3 acts as triple z; tested beside the probe.
        set_cfg(1'b1, 1'b1, 4'd0, '0, 1'b1, 1'b1, Z_TRIPLE_ALT);
        send_item(t_pins'((1 << PIN_ZMIN) | (1 << PIN_Z2MIN)), 3'b100, 3'b100, 1'b1, 1'b1);
        send_item(t_pins'((1 << PIN_ZMIN) | (1 << PIN_Z2MIN) | (1 << PIN_Z3MIN)),
                  3'b100, 3'b100, 1'b1, 1'b0);
        send_item(t_pins'((1 << PIN_Z2MAX) | (1 << PIN_Z3MAX)), 3'b100, 3'b000, 1'b0, 1'b0);

        // Debounce: a change reloads the countdown, validation when it runs out.
        set_cfg(1'b1, 1'b0, 4'd2, '0, 1'b0, 1'b0, Z_SINGLE);
        repeat (4) send_item(t_pins'(1 << PIN_XMIN), 3'b001, 3'b001, 1'b0, 1'b0);
        send_item('0, 3'b001, 3'b001, 1'b0, 1'b0);

        // Filtered but inactive: state moves, nothing stops.
        set_cfg(1'b0, 1'b0, 4'd1, '0, 1'b0, 1'b0, Z_SINGLE);
        send_item('1, 3'b111, 3'b111, 1'b0, 1'b0);
        send_item('1, 3'b111, 3'b111, 1'b0, 1'b0);

        // Random phases: fixed extremes for phases 0, 1, 2 and 4, random settings for the rest.
        for (p = 0; p < 8; p++) begin
            case (p)
                0: set_cfg(1'b1, 1'b0, 4'd0, '0, 1'b0, 1'b0, Z_SINGLE);
                1: set_cfg(1'b1, 1'b1, 4'd15, '1, 1'b1, 1'b1, Z_TRIPLE);
                2: set_cfg(1'b0, 1'b0, 4'd0, t_pins'($urandom), 1'b1, 1'b0, Z_DUAL);
                4: set_cfg(1'b0, 1'b1, 4'd4, t_pins'($urandom), 1'b0, 1'b1, Z_TRIPLE_ALT);
                default:
                    set_cfg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                        : 4'($urandom_range(0, 3)),
                            t_pins'($urandom), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            endcase
            // one phase runs back to back on both sides
            calm = (p == 3);
            random_phase(125);
            calm = 1'b0;
        end

        drain();
        repeat (5) @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
